>>> sv/pitch_bender_autozero_curve_assert.svh
// ----------------------------------------------------------------------------
// Pitch bender assertion macros
// Shorthand for the clocked concurrent assertions used by the block checker.
// ----------------------------------------------------------------------------
`ifndef PITCH_BENDER_AUTOZERO_CURVE_ASSERT_SVH
`define PITCH_BENDER_AUTOZERO_CURVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBAC_ASSERT_NOW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBAC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pbac_pkg.sv
// ----------------------------------------------------------------------------
// Pitch bender package
// Shared widths, constants, sequencer types and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package pbac_pkg;

   localparam int ADC_W   = 12;
   localparam int OFS_W   = 13;
   localparam int BEND_W  = 14;
   localparam int ROM_W   = 13;
   localparam int PROD_W  = 25;
   localparam int ACC_W   = 20;
   localparam int FRACT_W = 6;
   localparam int SEG_W   = 5;

   localparam logic [BEND_W-1:0] CENTER     = 14'd8000;
   localparam logic [PROD_W-1:0] CLIP_LIMIT = 25'(2047 * 4096);
   localparam logic [ADC_W-1:0]  ZERO_RESET = 12'd2048;
   localparam logic [ADC_W-1:0]  ZERO_MAX   = 12'd4095;

   typedef enum logic [2:0] {
      REG_CURVE_SELECT,
      REG_DEAD_RANGE,
      REG_SMALL_RANGE,
      REG_SETTLE_TICKS,
      REG_RAMP_STEP,
      REG_GAIN_FACTOR
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  curve_select;
      logic [7:0]  dead_range;
      logic [9:0]  small_range;
      logic [7:0]  settle_ticks;
      logic [5:0]  ramp_step;
      logic [12:0] gain_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASS,
      S_DEAD,
      S_GAIN,
      S_LOOKUP,
      S_MUL_LO,
      S_MUL_HI,
      S_EMIT,
      S_QUIET,
      S_CENTER
   } step_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_CLASS,
      UOP_GAIN,
      UOP_LOOKUP,
      UOP_MUL_LO,
      UOP_MUL_HI,
      UOP_EMIT_SHAPE,
      UOP_EMIT_CENTER
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_ACCEPT,
      COND_SAME,
      COND_INSIDE,
      COND_LAST_INSIDE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
      logic     last;
   } ucode_type;

   typedef struct packed {
      logic same;
      logic outside;
      logic last_outside;
   } status_type;

   // When the condition holds the sequencer jumps to the target, otherwise it
   // steps on, or returns to idle after a final step.
   function automatic ucode_type pbac_ucode(input step_type step);
      ucode_type word;
      case (step)
         S_IDLE:   word = '{UOP_LOAD,        COND_NO_ACCEPT,   S_IDLE,   1'b0};
         S_CLASS:  word = '{UOP_CLASS,       COND_SAME,        S_IDLE,   1'b0};
         S_DEAD:   word = '{UOP_NONE,        COND_INSIDE,      S_QUIET,  1'b0};
         S_GAIN:   word = '{UOP_GAIN,        COND_NEVER,       S_IDLE,   1'b0};
         S_LOOKUP: word = '{UOP_LOOKUP,      COND_NEVER,       S_IDLE,   1'b0};
         S_MUL_LO: word = '{UOP_MUL_LO,      COND_NEVER,       S_IDLE,   1'b0};
         S_MUL_HI: word = '{UOP_MUL_HI,      COND_NEVER,       S_IDLE,   1'b0};
         S_EMIT:   word = '{UOP_EMIT_SHAPE,  COND_OUT_BUSY,    S_EMIT,   1'b1};
         S_QUIET:  word = '{UOP_NONE,        COND_LAST_INSIDE, S_IDLE,   1'b0};
         S_CENTER: word = '{UOP_EMIT_CENTER, COND_OUT_BUSY,    S_CENTER, 1'b1};
         default:  word = '{UOP_NONE,        COND_NEVER,       S_IDLE,   1'b1};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

>>> sv/pbac_datapath.sv
// ----------------------------------------------------------------------------
// Pitch bender datapath
// Zero tracking, dead range test, gain multiply and curve interpolation,
// each operation selected by the current microcode step.
// ----------------------------------------------------------------------------
`default_nettype none

module pbac_datapath #(
   parameter int CURVE_POINTS = 33,
   parameter int NUM_CURVES   = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pbac_pkg::uop_type            op,
   input  wire pbac_pkg::cfg_type            cfg,
   input  wire logic [pbac_pkg::ADC_W-1:0]   adc_sample,
   output pbac_pkg::status_type              status,
   output logic [pbac_pkg::BEND_W-1:0]       bend_value
);
   import pbac_pkg::*;

   localparam int ROM_DEPTH = NUM_CURVES * CURVE_POINTS;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int IDX_W     = $clog2(CURVE_POINTS);
   localparam int LAST_IDX  = CURVE_POINTS - 1;

   logic [ROM_W-1:0] curve_rom [ROM_DEPTH];

   for (genvar c = 0; c < NUM_CURVES; c++) begin : g_curve
      for (genvar i = 0; i < CURVE_POINTS; i++) begin : g_point
         localparam longint K   = (c < 3) ? c : 1;
         localparam longint N   = CURVE_POINTS - 1;
         localparam longint X   = i;
         localparam longint NUM = 64'd8000 * X * ((2 - K) * N * N + K * X * X);
         localparam logic [ROM_W-1:0] VAL = ROM_W'(NUM / (2 * N * N * N));
         assign curve_rom[c * CURVE_POINTS + i] = VAL;
      end
   end

   logic [ADC_W-1:0]        zero_ff, zero_in;
   logic signed [OFS_W-1:0] last_ff, last_in;
   logic                    small_ff, small_in;
   logic [7:0]              settle_ff, settle_in;
   logic                    test_ff, test_in;
   logic                    ramp_ff, ramp_in;
   logic [ADC_W-1:0]        rem_ff, rem_in;
   logic                    up_ff, up_in;

   logic signed [OFS_W-1:0] v_ff;
   logic [ADC_W-1:0]        mag_ff;
   logic [ADC_W-1:0]        dmag_ff;
   logic                    neg_ff;
   logic                    outside_ff;
   logic                    last_outside_ff;
   logic [PROD_W-1:0]       p_ff;
   logic [ROM_W-1:0]        rom_lo_ff;
   logic [ROM_W-1:0]        rom_hi_ff;
   logic [FRACT_W-1:0]      fract_ff;
   logic                    clip_ff;
   logic [ACC_W-1:0]        acc_ff;

   logic signed [OFS_W-1:0] v_new;
   logic [ADC_W-1:0]        mag_new;
   logic                    small_now;
   logic [ADC_W:0]          zero_sum;
   logic [ADC_W-1:0]        ramp_step_ext;
   logic [ADC_W-1:0]        dead_ext;
   logic [ADC_W-1:0]        last_mag;
   logic [SEG_W-1:0]        seg;
   logic [FRACT_W-1:0]      fract;
   logic                    at_end;
   logic [IDX_W-1:0]        lo_idx;
   logic [IDX_W-1:0]        hi_idx;
   logic [ROM_AW-1:0]       lo_addr;
   logic [ROM_AW-1:0]       hi_addr;
   logic [ROM_W-1:0]        mul_a;
   logic [FRACT_W:0]        mul_b;
   logic [ACC_W-1:0]        prod;
   logic [BEND_W-1:0]       shape;

   assign v_new         = $signed({1'b0, adc_sample}) - $signed({1'b0, zero_ff});
   assign mag_new       = v_new[OFS_W-1] ? ADC_W'(-v_new) : v_new[ADC_W-1:0];
   assign small_now     = mag_new < ADC_W'(cfg.small_range);
   assign ramp_step_ext = ADC_W'(cfg.ramp_step);
   assign zero_sum      = {1'b0, zero_ff} + {1'b0, ramp_step_ext};
   assign dead_ext      = ADC_W'(cfg.dead_range);
   assign last_mag      = last_ff[OFS_W-1] ? ADC_W'(-last_ff) : last_ff[ADC_W-1:0];

   always_comb begin
      zero_in   = zero_ff;
      small_in  = small_ff;
      settle_in = settle_ff;
      test_in   = test_ff;
      ramp_in   = ramp_ff;
      rem_in    = rem_ff;
      up_in     = up_ff;
      if (op == UOP_LOAD) begin
         if (small_now) begin
            if (!small_ff) begin
               settle_in = '0;
               test_in   = 1'b1;
            end
            small_in = 1'b1;
         end else begin
            if (small_ff) begin
               test_in = 1'b0;
            end
            small_in = 1'b0;
         end
         if (test_in) begin
            if (settle_in < cfg.settle_ticks) begin
               settle_in = settle_in + 8'd1;
            end else begin
               test_in = 1'b0;
               ramp_in = 1'b1;
               up_in   = !v_new[OFS_W-1] && (v_new != '0);
               rem_in  = mag_new;
            end
         end
         if (ramp_in) begin
            if (rem_in <= ramp_step_ext) begin
               rem_in  = '0;
               ramp_in = 1'b0;
            end else begin
               rem_in = rem_in - ramp_step_ext;
               if (up_in) begin
                  zero_in = (zero_sum > {1'b0, ZERO_MAX}) ? ZERO_MAX : zero_sum[ADC_W-1:0];
               end else begin
                  zero_in = (zero_ff < ramp_step_ext) ? '0 : zero_ff - ramp_step_ext;
               end
            end
         end
      end
   end

   assign last_in = (op == UOP_CLASS) ? v_ff : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff   <= ZERO_RESET;
         last_ff   <= '0;
         small_ff  <= 1'b0;
         settle_ff <= '0;
         test_ff   <= 1'b0;
         ramp_ff   <= 1'b0;
         rem_ff    <= '0;
         up_ff     <= 1'b0;
      end else begin
         zero_ff   <= zero_in;
         last_ff   <= last_in;
         small_ff  <= small_in;
         settle_ff <= settle_in;
         test_ff   <= test_in;
         ramp_ff   <= ramp_in;
         rem_ff    <= rem_in;
         up_ff     <= up_in;
      end
   end

   assign seg     = p_ff[22:18];
   assign fract   = p_ff[17:12];
   assign at_end  = int'(seg) >= LAST_IDX;
   assign lo_idx  = at_end ? IDX_W'(LAST_IDX) : IDX_W'(seg);
   assign hi_idx  = at_end ? IDX_W'(LAST_IDX) : IDX_W'(seg) + IDX_W'(1);
   assign lo_addr = ROM_AW'(int'(cfg.curve_select) * CURVE_POINTS + int'(lo_idx));
   assign hi_addr = ROM_AW'(int'(cfg.curve_select) * CURVE_POINTS + int'(hi_idx));

   assign mul_a = (op == UOP_MUL_HI) ? rom_hi_ff : rom_lo_ff;
   assign mul_b = (op == UOP_MUL_HI) ? {1'b0, fract_ff} : 7'd64 - {1'b0, fract_ff};
   assign prod  = ACC_W'(mul_a) * ACC_W'(mul_b);

   always_ff @(posedge clock) begin
      case (op)
         UOP_LOAD: begin
            v_ff   <= v_new;
            mag_ff <= mag_new;
         end
         UOP_CLASS: begin
            outside_ff      <= mag_ff > dead_ext;
            last_outside_ff <= last_mag > dead_ext;
            neg_ff          <= v_ff[OFS_W-1];
            dmag_ff         <= mag_ff - dead_ext;
         end
         UOP_GAIN: begin
            p_ff <= PROD_W'(dmag_ff) * PROD_W'(cfg.gain_factor);
         end
         UOP_LOOKUP: begin
            rom_lo_ff <= curve_rom[lo_addr];
            rom_hi_ff <= curve_rom[hi_addr];
            fract_ff  <= at_end ? '0 : fract;
            clip_ff   <= p_ff > CLIP_LIMIT;
         end
         UOP_MUL_LO: begin
            acc_ff <= prod;
         end
         UOP_MUL_HI: begin
            acc_ff <= acc_ff + prod;
         end
         default: begin
         end
      endcase
   end

   assign status.same         = (v_ff == last_ff);
   assign status.outside      = outside_ff;
   assign status.last_outside = last_outside_ff;

   assign shape = clip_ff ? CENTER : acc_ff[ACC_W-1:FRACT_W];

   always_comb begin
      if (op == UOP_EMIT_CENTER) begin
         bend_value = CENTER;
      end else if (neg_ff) begin
         bend_value = CENTER - shape;
      end else begin
         bend_value = CENTER + shape;
      end
   end

endmodule

`default_nettype wire

>>> sv/pbac_sequencer.sv
// ----------------------------------------------------------------------------
// Pitch bender sequencer
// Step counter over the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pbac_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic                  out_busy,
   input  wire pbac_pkg::status_type  status,
   output logic                       idle,
   output pbac_pkg::uop_type          op
);
   import pbac_pkg::*;

   step_type  pc_ff, pc_in;
   ucode_type word;
   logic      take;

   assign word = pbac_ucode(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:       take = 1'b0;
         COND_NO_ACCEPT:   take = !in_valid;
         COND_SAME:        take = status.same;
         COND_INSIDE:      take = !status.outside;
         COND_LAST_INSIDE: take = !status.last_outside;
         COND_OUT_BUSY:    take = out_busy;
         default:          take = 1'b0;
      endcase
      if (take) begin
         pc_in = word.target;
      end else if (word.last) begin
         pc_in = S_IDLE;
      end else begin
         pc_in = step_type'(pc_ff + 4'd1);
      end
   end

   always_comb begin
      idle = (pc_ff == S_IDLE);
      if (word.op == UOP_LOAD && !in_valid) begin
         op = UOP_NONE;
      end else begin
         op = word.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/pitch_bender_autozero_curve.sv
// ----------------------------------------------------------------------------
// Pitch bender with auto-zero and response curve
// Tracks the bender zero point, removes the dead range, applies gain and a
// selectable interpolated curve, and reports changes of the bend position.
//
//   Channel  Ports                          Direction  Contents
//   req      req_valid/req_stall            in         adc_sample
//   rsp      rsp_valid/rsp_stall            out        bend_value
//   csr      psel/penable/pwrite/paddr/...  in/out     six config registers
//
// Steps, set by the microcode program: load and class for an unchanged offset;
// dead, quiet inside the dead range; center for a return; gain to emit if shaped.
// A transaction is taken only while the sequencer sits at its idle step.
// A stalled result waits in the output register; a further result holds the
// emit step, and so the input, until that register frees.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_bender_autozero_curve #(
   parameter int CURVE_POINTS = 33,
   parameter int NUM_CURVES   = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [pbac_pkg::ADC_W-1:0]  req_adc_sample,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [pbac_pkg::BEND_W-1:0]      rsp_bend_value,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [4:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import pbac_pkg::*;

   localparam logic [1:0] CURVE_RESET = 2'((1 < NUM_CURVES) ? 1 : 0);

   cfg_type           cfg_ff, cfg_in;
   logic              csr_write;
   logic [2:0]        reg_index;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BEND_W-1:0] rsp_bend_value_ff;
   logic              out_busy;
   logic              load_out;
   logic              idle;
   uop_type           op;
   status_type        status;
   logic [BEND_W-1:0] bend_value;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_CURVE_SELECT: begin
               if (int'(pwdata[1:0]) < NUM_CURVES) begin
                  cfg_in.curve_select = pwdata[1:0];
               end
            end
            REG_DEAD_RANGE:   cfg_in.dead_range   = pwdata[7:0];
            REG_SMALL_RANGE:  cfg_in.small_range  = pwdata[9:0];
            REG_SETTLE_TICKS: cfg_in.settle_ticks = pwdata[7:0];
            REG_RAMP_STEP:    cfg_in.ramp_step    = pwdata[5:0];
            REG_GAIN_FACTOR:  cfg_in.gain_factor  = pwdata[12:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CURVE_SELECT: prdata = 32'(cfg_ff.curve_select);
         REG_DEAD_RANGE:   prdata = 32'(cfg_ff.dead_range);
         REG_SMALL_RANGE:  prdata = 32'(cfg_ff.small_range);
         REG_SETTLE_TICKS: prdata = 32'(cfg_ff.settle_ticks);
         REG_RAMP_STEP:    prdata = 32'(cfg_ff.ramp_step);
         REG_GAIN_FACTOR:  prdata = 32'(cfg_ff.gain_factor);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_select <= CURVE_RESET;
         cfg_ff.dead_range   <= 8'd20;
         cfg_ff.small_range  <= 10'd200;
         cfg_ff.settle_ticks <= 8'd80;
         cfg_ff.ramp_step    <= 6'd8;
         cfg_ff.gain_factor  <= 13'd4540;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !idle;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign load_out  = (op == UOP_EMIT_SHAPE || op == UOP_EMIT_CENTER) && !out_busy;

   pbac_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .out_busy (out_busy),
      .status   (status),
      .idle     (idle),
      .op       (op)
   );

   pbac_datapath #(
      .CURVE_POINTS (CURVE_POINTS),
      .NUM_CURVES   (NUM_CURVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .cfg        (cfg_ff),
      .adc_sample (req_adc_sample),
      .status     (status),
      .bend_value (bend_value)
   );

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_bend_value_ff <= bend_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bend_value = rsp_bend_value_ff;

endmodule

`default_nettype wire

>>> sv/pbac_checker.sv
// ----------------------------------------------------------------------------
// Pitch bender port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pitch_bender_autozero_curve_assert.svh"

module pbac_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [pbac_pkg::BEND_W-1:0] rsp_bend_value,
   input wire logic                        pready
);

   `PBAC_ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid, "result valid after reset")

   `PBAC_ASSERT_NEXT(a_rsp_holds, clock, !reset && rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bend_value), "stalled result changed")

   `PBAC_ASSERT_NOW(a_bend_range, clock, !reset && rsp_valid, rsp_bend_value <= 14'd16000, "bend value above full scale")

   `PBAC_ASSERT_NEXT(a_busy_after_accept, clock, !reset && req_valid && !req_stall, req_stall, "sample accepted in consecutive cycles")

   `PBAC_ASSERT_NOW(a_pready_high, clock, 1'b1, pready, "register port not ready")

endmodule

bind pitch_bender_autozero_curve pbac_checker u_pbac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_bend_value (rsp_bend_value),
   .pready         (pready)
);

`default_nettype wire
